// ----- rtl/hbd_pkg.sv -----
// Shared types, constants and helper functions of the Hamming block decoder.
package hbd_pkg;

  localparam int BYTE_W = 8;   // code and data byte width
  localparam int DBC_W  = 7;   // data byte count register width
  localparam int SYN_W  = 10;  // syndrome and code bit position width
  localparam int LEN_W  = 10;  // code length width
  localparam int REM_W  = 4;   // used bits of the final code byte, 1..8
  localparam int NC_W   = 4;   // bit counts while packing data bits
  localparam int MAX_PARITY = 10;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SYN,
    ST_EMIT
  } state_e;

  // Smallest parity count r with 2^r >= m + r + 1.
  function automatic logic [NC_W-1:0] parity_count(input logic [LEN_W-1:0] m);
    logic [NC_W-1:0] r;
    r = NC_W'(MAX_PARITY);
    for (int k = MAX_PARITY; k >= 1; k--) begin
      if ((int'(m) + k + 1) <= (1 << k)) begin
        r = NC_W'(k);
      end
    end
    return r;
  endfunction

  // XOR of the positions of the set bits of one aligned code byte.
  // Bit 7 of w is the earliest position, base + 1.
  function automatic logic [SYN_W-1:0] syn_part(input logic [BYTE_W-1:0] w,
                                                input logic [SYN_W-1:0]  base);
    logic [SYN_W-1:0] acc;
    acc = '0;
    for (int off = 0; off < BYTE_W; off++) begin
      if (w[BYTE_W-1-off]) begin
        acc = acc ^ (base + SYN_W'(off + 1));
      end
    end
    return acc;
  endfunction

endpackage

// ----- rtl/hbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module hbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 66
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold data while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hamming_block_decoder_core.sv -----
// Top level of the Hamming block decoder: code byte store, syndrome and data byte output.
//
// The block takes code bytes of a Hamming single-error-correcting block, parity bits at
// the power-of-two positions counted from 1, MSB of each byte first, and buffers them in
// a code byte RAM until the item flagged last. Code length L = 8*D + r follows from the
// data byte count D latched at that last item (0 reads as 1, values above MAX_DATA_BYTES
// as MAX_DATA_BYTES); the final code byte holds its bits in its low end. While loading,
// one item is taken per cycle. After the last item the block reads the E = ceil(L/8)
// code bytes back through the RAM's one read port, one per cycle, to form the syndrome,
// then reads them a second time, one per cycle while the output is not stalled,
// correcting the named bit and packing the data bits; one data byte leaves per code
// byte that completes one. E is D + 1 or D + 2. Input is refused from the last item
// until the final data byte has entered the output register. The code store has no
// reset and needs no clearing pass: bytes that did not arrive read as zero. The data
// byte count register may be written at any time.
module hamming_block_decoder_core
  import hbd_pkg::*;
#(
  parameter int MAX_DATA_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [DBC_W-1:0]  cfg_wdata_i,
  // code byte input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] code_byte_i,
  input  logic              last_byte_i,
  // data byte output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] data_byte_o,
  output logic              last_data_o,
  output logic              error_found_o,
  output logic              error_fixed_o,
  output logic [SYN_W-1:0]  syndrome_o
);

  localparam int DEPTH  = (MAX_DATA_BYTES * 8 + MAX_PARITY + 7) / 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FB_W   = SYN_W - 3;
  localparam int ACC_W  = BYTE_W - 1;
  localparam int CMB_W  = 2 * BYTE_W - 1;

  state_e state_q, state_d;

  logic [DBC_W-1:0]  dbc_q;
  logic [CNT_W-1:0]  rcvd_q, rcvd_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CNT_W-1:0]  nbytes_q, nbytes_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [SYN_W-1:0]  syn_q, syn_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0] use_idx_q, use_idx_d;
  logic              pend_q, pend_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [NC_W-1:0]   cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q, out_found_q, out_fixed_q;
  logic [SYN_W-1:0]  out_syn_q;

  // control
  logic in_fire, last_fire, issue, consume, emit_out, slot_free, syn_done, emit_done;

  // block geometry at the last item
  logic [DBC_W-1:0] d_clamp;
  logic [LEN_W-1:0] m_bits, len_c, len_p7;
  logic [NC_W-1:0]  r_bits;

  // pending code byte datapath
  logic [BYTE_W-1:0] raw, aligned, flipped, flip_mask, new_bits;
  logic              is_last_b, present, found, fixed, par_here;
  logic [SYN_W-1:0]  flip_pos;
  logic [NC_W-1:0]   nv, nc, total;
  logic [CMB_W-1:0]  comb_bits, rest_mask;
  logic [BYTE_W-1:0] out_byte;

  logic              ram_we;

  // Code byte store
  hbd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rcvd_q[ADDR_W-1:0]),
    .wdata_i (code_byte_i),
    .re_i    (issue),
    .raddr_i (rd_idx_q[ADDR_W-1:0]),
    .rdata_o (raw)
  );

  // Geometry from the clamped byte count
  always_comb begin
    if (dbc_q == '0) begin
      d_clamp = DBC_W'(1);
    end else if (dbc_q > DBC_W'(MAX_DATA_BYTES)) begin
      d_clamp = DBC_W'(MAX_DATA_BYTES);
    end else begin
      d_clamp = dbc_q;
    end
    m_bits = LEN_W'({d_clamp, 3'b000});
    r_bits = parity_count(m_bits);
    len_c  = m_bits + LEN_W'(r_bits);
    len_p7 = len_c + LEN_W'(7);
  end

  // Align, mask and correct the pending code byte
  always_comb begin
    is_last_b = (CNT_W'(use_idx_q) == (nbytes_q - CNT_W'(1)));
    present   = (CNT_W'(use_idx_q) < rcvd_q);
    if (!present) begin
      aligned = '0;
    end else if (is_last_b) begin
      aligned = raw << (REM_W'(BYTE_W) - rem_q);
    end else begin
      aligned = raw;
    end
    found    = (syn_q != '0);
    fixed    = found && (syn_q <= len_q);
    flip_pos = syn_q - SYN_W'(1);
    if (fixed && (flip_pos[SYN_W-1:3] == FB_W'(use_idx_q))) begin
      flip_mask = 8'h80 >> flip_pos[2:0];
    end else begin
      flip_mask = '0;
    end
    flipped = aligned ^ flip_mask;
  end

  // Drop parity positions and pack data bits
  always_comb begin
    nv       = is_last_b ? rem_q : NC_W'(BYTE_W);
    par_here = (((use_idx_q + ADDR_W'(1)) & use_idx_q) == '0) && (nv == NC_W'(BYTE_W));
    if (use_idx_q == '0) begin
      // first byte: positions 3, 5, 6 and 7 carry data
      nc       = NC_W'(4);
      new_bits = {4'b0000, flipped[5], flipped[3], flipped[2], flipped[1]};
    end else begin
      nc       = nv - NC_W'(par_here);
      new_bits = flipped >> (NC_W'(BYTE_W) - nc);
    end
    total     = cnt_q + nc;
    comb_bits = (CMB_W'(acc_q) << nc) | CMB_W'(new_bits);
    out_byte  = BYTE_W'(comb_bits >> (total - NC_W'(BYTE_W)));
    rest_mask = (CMB_W'(1) << (total - NC_W'(BYTE_W))) - CMB_W'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (last_fire) begin
          state_d = ST_SYN;
        end
      end
      ST_SYN: begin
        if (syn_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Handshake, RAM and pass control
  always_comb begin
    slot_free  = !out_valid_q || out_ready_i;
    in_ready_o = 1'b0;
    issue      = 1'b0;
    consume    = 1'b0;
    emit_out   = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
      end
      ST_SYN: begin
        consume = pend_q;
        issue   = (rd_idx_q < nbytes_q);
      end
      ST_EMIT: begin
        consume  = pend_q && ((total < NC_W'(BYTE_W)) || slot_free);
        emit_out = consume && (total >= NC_W'(BYTE_W));
        issue    = (!pend_q || consume) && (rd_idx_q < nbytes_q);
      end
      default: ;
    endcase
    in_fire   = in_valid_i && in_ready_o;
    last_fire = in_fire && last_byte_i;
    ram_we    = in_fire && (rcvd_q < CNT_W'(DEPTH));
    syn_done  = (state_q == ST_SYN) && consume && is_last_b;
    emit_done = (state_q == ST_EMIT) && consume && is_last_b;
  end

  // Register next values
  always_comb begin
    rcvd_d    = rcvd_q;
    len_d     = len_q;
    nbytes_d  = nbytes_q;
    rem_d     = rem_q;
    syn_d     = syn_q;
    rd_idx_d  = rd_idx_q;
    use_idx_d = use_idx_q;
    // hold the pending byte while the output is stalled
    pend_d    = issue || (pend_q && !consume);
    acc_d     = acc_q;
    cnt_d     = cnt_q;

    // count stored bytes, saturate at the store depth
    if (ram_we) begin
      rcvd_d = rcvd_q + CNT_W'(1);
    end
    // latch geometry and restart the passes on the last item
    if (last_fire) begin
      len_d    = len_c;
      nbytes_d = CNT_W'(len_p7[LEN_W-1:3]);
      rem_d    = (len_c[2:0] == 3'b000) ? REM_W'(BYTE_W) : REM_W'(len_c[2:0]);
      syn_d    = '0;
      rd_idx_d = '0;
    end
    // advance the read pointer
    if (issue) begin
      rd_idx_d  = rd_idx_q + CNT_W'(1);
      use_idx_d = rd_idx_q[ADDR_W-1:0];
    end
    // accumulate the syndrome
    if ((state_q == ST_SYN) && consume) begin
      syn_d = syn_q ^ syn_part(aligned, SYN_W'({use_idx_q, 3'b000}));
    end
    // rewind for the output pass
    if (syn_done) begin
      rd_idx_d = '0;
      acc_d    = '0;
      cnt_d    = '0;
    end
    // pack data bits
    if ((state_q == ST_EMIT) && consume) begin
      if (emit_out) begin
        acc_d = ACC_W'(comb_bits & rest_mask);
        cnt_d = total - NC_W'(BYTE_W);
      end else begin
        acc_d = ACC_W'(comb_bits);
        cnt_d = total;
      end
    end
    // start afresh after the block
    if (emit_done) begin
      rcvd_d = '0;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      dbc_q       <= DBC_W'(1);
      rcvd_q      <= '0;
      syn_q       <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rcvd_q      <= rcvd_d;
      syn_q       <= syn_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dbc_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    nbytes_q  <= nbytes_d;
    rem_q     <= rem_d;
    use_idx_q <= use_idx_d;
    acc_q     <= acc_d;
    if (emit_out) begin
      out_data_q  <= out_byte;
      out_last_q  <= is_last_b;
      out_found_q <= found;
      out_fixed_q <= fixed;
      out_syn_q   <= syn_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = out_data_q;
  assign last_data_o   = out_last_q;
  assign error_found_o = out_found_q;
  assign error_fixed_o = out_fixed_q;
  assign syndrome_o    = out_syn_q;

endmodule

// ----- test/hamming_block_decoder_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Hamming block decoder core: directed table, then random blocks.
module hamming_block_decoder_core_tb
  import hbd_pkg::*;
();

  localparam int MAX_BYTES  = 64;
  localparam int STORE_N    = 66;
  localparam int MAX_LEN    = 8 * MAX_BYTES + 10;
  localparam int HALF_CYC   = 5;
  localparam int RAND_ITEMS = 410;
  localparam int CALM_ITEMS = 60;
  localparam int HOLD_CYC   = 16;
  localparam int DRAIN_CYC  = 40;
  localparam int CYC_LIMIT  = 300000;

  // One decoded data byte with its block status
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              found;
    logic              fixed;
    logic [SYN_W-1:0]  syn;
  } dec_byte_t;

  // One row of the directed table: a register write or one code byte
  typedef struct packed {
    logic              wr;
    logic [DBC_W-1:0]  cnt;
    logic [BYTE_W-1:0] code;
    logic              last;
    logic              known;
    dec_byte_t         want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [DBC_W-1:0]  cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [BYTE_W-1:0] code_byte_i;
  logic              last_byte_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [BYTE_W-1:0] data_byte_o;
  logic              last_data_o;
  logic              error_found_o;
  logic              error_fixed_o;
  logic [SYN_W-1:0]  syndrome_o;

  // Decoder copy: held code bytes and the byte count register
  logic [BYTE_W-1:0] blk_bytes [STORE_N];
  int unsigned       blk_fill;
  logic [DBC_W-1:0]  byte_count_reg;

  dec_byte_t         pending_q [$];
  logic [BYTE_W-1:0] tx_q [$];
  dir_row_t          dir_tab [$];

  int unsigned items_sent, blocks_done, checked, mismatches, cfg_writes;
  int unsigned fixed_blocks, outside_blocks;
  int unsigned cycles = 0;
  bit          tx_idle_on, rx_stall_on;

  hamming_block_decoder_core #(
    .MAX_DATA_BYTES(MAX_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .code_byte_i   (code_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .last_data_o   (last_data_o),
    .error_found_o (error_found_o),
    .error_fixed_o (error_fixed_o),
    .syndrome_o    (syndrome_o)
  );

  always #HALF_CYC clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("%0t: timeout, %0d data bytes still expected", $time, pending_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Code bit length for d data bytes
  function automatic int unsigned code_len(input int unsigned d);
    int unsigned m, r;
    m = 8 * d;
    r = 0;
    while ((1 << r) < m + r + 1) r++;
    return m + r;
  endfunction

  // Byte count in force: zero reads as one, large values saturate
  function automatic int unsigned eff_count(input logic [DBC_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_BYTES) return MAX_BYTES;
    return v;
  endfunction

  // Form the syndrome of the held block, correct one bit and, when keep is set, queue the data bytes
  task automatic hamming_decode(input bit keep);
    int unsigned      d, len, nb, rem, p, bi, off, sh, k, nbits;
    logic [SYN_W-1:0] syn;
    logic [BYTE_W-1:0] acc;
    bit               cw [1:MAX_LEN];
    dec_byte_t        r;
    d   = eff_count(byte_count_reg);
    len = code_len(d);
    nb  = (len + 7) / 8;
    rem = len - 8 * (nb - 1);
    syn = '0;
    // unpack, missing bytes read as zero
    for (p = 1; p <= len; p++) begin
      bi = (p - 1) / 8;
      off = (p - 1) % 8;
      sh = (bi == nb - 1) ? rem - 1 - off : 7 - off;
      cw[p] = (bi < blk_fill) ? blk_bytes[bi][sh] : 1'b0;
      if (cw[p]) syn = syn ^ SYN_W'(p);
    end
    r.found = (syn != 0);
    r.fixed = 1'b0;
    r.syn   = syn;
    if (r.found && syn <= len) begin
      cw[syn] = ~cw[syn];
      r.fixed = 1'b1;
      fixed_blocks++;
    end else if (r.found) begin
      outside_blocks++;
    end
    // gather data bits, skip parity positions
    k = 0;
    nbits = 0;
    acc = '0;
    for (p = 1; p <= len && k < d; p++) begin
      if ((p & (p - 1)) == 0) continue;
      acc = {acc[BYTE_W-2:0], cw[p]};
      nbits++;
      if (nbits == 8) begin
        r.data = acc;
        r.last = (k == d - 1);
        if (keep) pending_q = {pending_q, r};
        k++;
        nbits = 0;
        acc = '0;
      end
    end
    blk_fill = 0;
  endtask

  // Build a valid code block for d random data bytes, then flip nerr bits
  task automatic encode_block(input int unsigned d, input int unsigned nerr);
    int unsigned       len, nb, rem, p, bi, off, sh;
    logic [SYN_W-1:0]  s;
    logic [BYTE_W-1:0] w;
    bit                cw [1:MAX_LEN];
    len = code_len(d);
    nb  = (len + 7) / 8;
    rem = len - 8 * (nb - 1);
    s = '0;
    for (p = 1; p <= len; p++) begin
      cw[p] = ((p & (p - 1)) != 0) ? 1'($urandom_range(0, 1)) : 1'b0;
      if (cw[p]) s = s ^ SYN_W'(p);
    end
    // parity bits cancel the data syndrome
    for (p = 0; p < SYN_W; p++) begin
      if (s[p]) cw[1 << p] = 1'b1;
    end
    repeat (nerr) begin
      p = $urandom_range(1, len);
      cw[p] = ~cw[p];
    end
    // pack MSB first, final byte right-aligned
    tx_q.delete();
    w = '0;
    for (p = 1; p <= len; p++) begin
      bi = (p - 1) / 8;
      off = (p - 1) % 8;
      sh = (bi == nb - 1) ? rem - 1 - off : 7 - off;
      w[sh] = cw[p];
      if (off == 7 || p == len) begin
        tx_q = {tx_q, w};
        w = '0;
      end
    end
  endtask

  // Drain, let the block settle, then write the byte count
  task automatic set_count(input logic [DBC_W-1:0] v);
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (HOLD_CYC) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    byte_count_reg = v;
    cfg_writes++;
  endtask

  // Offer one code byte, hold until taken, then advance the predictor
  task automatic push_code(input logic [BYTE_W-1:0] b, input logic last, input bit known,
                           input dec_byte_t want);
    int unsigned gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    code_byte_i = b;
    last_byte_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    if (blk_fill < STORE_N) begin
      blk_bytes[blk_fill] = b;
      blk_fill++;
    end
    if (last) begin
      hamming_decode(!known);
      if (known) pending_q = {pending_q, want};
      blocks_done++;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic dir_row_t cfg_row(input logic [DBC_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.wr = 1'b1;
    r.cnt = v;
    return r;
  endfunction

  function automatic dir_row_t byte_row(input logic [BYTE_W-1:0] b, input logic last);
    dir_row_t r;
    r = '0;
    r.code = b;
    r.last = last;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic [BYTE_W-1:0] b,
                                         input logic [BYTE_W-1:0] data, input logic found,
                                         input logic fixed, input logic [SYN_W-1:0] syn);
    dir_row_t r;
    r = '0;
    r.code  = b;
    r.last  = 1'b1;
    r.known = 1'b1;
    r.want  = {data, 1'b1, found, fixed, syn};
    return r;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(input dir_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  // Receiver: stall in random bursts while enabled
  initial begin : rx_side
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_ready_i = 1'b0;
        hold--;
      end else begin
        out_ready_i = 1'b1;
        if (rx_stall_on && $urandom_range(0, 11) == 0) hold = $urandom_range(1, 18);
      end
    end
  end

  // Check each taken data byte against the oldest expectation
  always @(posedge clk_i) begin : check_out
    dec_byte_t got, want;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      got = {data_byte_o, last_data_o, error_found_o, error_fixed_o, syndrome_o};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 20)
          $display("%0t: unexpected data byte, expected none, got data=%h syn=%0d",
                   $time, got.data, got.syn);
      end else begin
        want = pending_q.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          // fields: data, last/found/fixed, syndrome
          if (mismatches <= 20)
            $display("%0t: byte %0d mismatch, expected %h %b%b%b %0d, got %h %b%b%b %0d",
                     $time, checked, want.data, want.last, want.found, want.fixed,
                     want.syn, got.data, got.last, got.found, got.fixed, got.syn);
        end
      end
    end
  end

  initial begin : main
    int unsigned i, d, nblk, kind, cnt, n, rand_start;
    bit          calm;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    code_byte_i = '0;
    last_byte_i = 1'b0;
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    byte_count_reg = 7'd1;
    blk_fill = 0;

    // One data byte per block after reset: code bits 1..8 in byte 0, 9..12 in byte 1
    // clean all-zero block
    add_row(byte_row(8'h00, 1'b0));
    add_row(known_row(8'h00, 8'h00, 1'b0, 1'b0, 10'd0));
    // parity bit at position one flipped
    add_row(byte_row(8'h80, 1'b0));
    add_row(known_row(8'h00, 8'h00, 1'b1, 1'b1, 10'd1));
    // all ones: syndrome names the last code bit
    add_row(byte_row(8'hFF, 1'b0));
    add_row(known_row(8'h0F, 8'hFE, 1'b1, 1'b1, 10'd12));
    // syndrome past the end of the code, nothing flipped
    add_row(byte_row(8'h09, 1'b0));
    add_row(known_row(8'h00, 8'h40, 1'b1, 1'b0, 10'd13));
    // unused high bits of the final byte take no part
    add_row(byte_row(8'h00, 1'b0));
    add_row(known_row(8'hF0, 8'h00, 1'b0, 1'b0, 10'd0));
    // short block: the missing byte reads as zero
    add_row(known_row(8'h20, 8'h00, 1'b1, 1'b1, 10'd3));
    // long block: bytes past the code are ignored
    add_row(byte_row(8'h00, 1'b0));
    add_row(byte_row(8'h00, 1'b0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(known_row(8'hFF, 8'h00, 1'b0, 1'b0, 10'd0));
    // count of zero acts as one
    add_row(cfg_row(7'd0));
    add_row(byte_row(8'hFF, 1'b0));
    add_row(known_row(8'h0F, 8'hFE, 1'b1, 1'b1, 10'd12));
    // two data bytes, five-bit final byte
    add_row(cfg_row(7'd2));
    add_row(byte_row(8'hA5, 1'b0));
    add_row(byte_row(8'h3C, 1'b0));
    add_row(byte_row(8'h1F, 1'b1));
    // top count saturates, one byte in and the largest block out
    add_row(cfg_row(7'd127));
    add_row(byte_row(8'hFF, 1'b1));
    add_row(cfg_row(7'd64));

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part
    for (i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].wr) set_count(dir_tab[i].cnt);
      else push_code(dir_tab[i].code, dir_tab[i].last, dir_tab[i].known, dir_tab[i].want);
    end

    // Random part: phases of one byte count, mostly well-formed blocks
    rand_start = items_sent;
    while (items_sent - rand_start < RAND_ITEMS) begin
      calm = (items_sent - rand_start) >= RAND_ITEMS - CALM_ITEMS;
      n = $urandom_range(0, 23);
      if (n == 0) cnt = 64;
      else if (n == 1) cnt = $urandom_range(65, 127);
      else if (n == 2) cnt = 0;
      else if (n <= 6) cnt = $urandom_range(9, 24);
      else cnt = $urandom_range(1, 8);
      set_count(DBC_W'(cnt));
      d = eff_count(DBC_W'(cnt));
      nblk = (d > 8) ? $urandom_range(1, 2) : $urandom_range(2, 6);
      tx_idle_on  = !calm && ($urandom_range(0, 3) != 0);
      rx_stall_on = !calm && ($urandom_range(0, 3) != 0);
      repeat (nblk) begin
        kind = $urandom_range(0, 19);
        encode_block(d, (kind < 4) ? 0 : ((kind < 10) ? 1 : 2));
        if (kind >= 13 && kind <= 15) begin
          // noise block
          for (i = 0; i < tx_q.size(); i++) tx_q[i] = BYTE_W'($urandom);
        end else if (kind == 16 || kind == 17) begin
          // cut short before the final byte
          n = $urandom_range(1, tx_q.size() - 1);
          while (tx_q.size() > n) void'(tx_q.pop_back());
        end else if (kind >= 18) begin
          // trailing extra bytes
          repeat ($urandom_range(1, 4)) tx_q = {tx_q, BYTE_W'($urandom)};
        end
        for (i = 0; i < tx_q.size(); i++)
          push_code(tx_q[i], (i == tx_q.size() - 1), 1'b0, '0);
      end
    end

    // Drain and settle
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);

    $display("Sent %0d code bytes in %0d blocks over %0d byte count writes;",
             items_sent, blocks_done, cfg_writes);
    $display("%0d data bytes checked, %0d blocks corrected, %0d outside the code, %0d mismatches.",
             checked, fixed_blocks, outside_blocks, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hbd_pkg.sv
rtl/hbd_ram.sv
rtl/hamming_block_decoder_core.sv
test/hamming_block_decoder_core_tb.sv
